// ===== src/vtp_pkg.sv =====
`default_nettype none

package vtp_pkg;

  typedef logic signed [31:0] word_t;

  localparam int COEF_COUNT  = 48;
  localparam int MV_BASE     = 0;
  localparam int NM_BASE     = 16;
  localparam int PJ_BASE     = 32;
  localparam int IDX_W       = 6;
  localparam int IN_TDATA_W  = 264;
  localparam int OUT_TDATA_W = 224;

  localparam int IDX_LSB  = 0;
  localparam int VAL_LSB  = 6;
  localparam int POS_LSB  = 38;
  localparam int NORM_LSB = 166;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_VERTEX = 1'b1
  } cmd_e;

  typedef word_t [COEF_COUNT-1:0] coef_arr_t;

  typedef struct packed {
    word_t [2:0] norm;
    word_t [3:0] pos;
  } vtx_t;

  typedef struct packed {
    word_t [2:0] view_norm;
    word_t [3:0] clip;
  } result_t;

  typedef struct packed {
    logic q_full;
    logic q_empty;
    logic pipe_busy;
  } flow_t;

endpackage

`default_nettype wire

// ===== src/vtp_fifo.sv =====
`default_nettype none

module vtp_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire vtp_pkg::vtx_t din_i,
  input  wire logic          pop_i,
  output vtp_pkg::vtx_t      dout_o,
  output logic               full_o,
  output logic               empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  vtp_pkg::vtx_t mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign dout_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= din_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/vtp_front.sv =====
`default_nettype none

module vtp_front (
  input  wire logic                               clk_i,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [vtp_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  wire logic                               s_axis_tuser,
  input  wire vtp_pkg::flow_t                     flow_i,
  output logic                                    push_o,
  output vtp_pkg::vtx_t                           vtx_o,
  output vtp_pkg::coef_arr_t                      coef_o
);

  vtp_pkg::coef_arr_t              coef_q;
  logic                            is_vtx;
  logic [vtp_pkg::IDX_W-1:0]       idx;
  vtp_pkg::word_t                  val;
  logic                            ld_acc;

  assign is_vtx = (vtp_pkg::cmd_e'(s_axis_tuser) == vtp_pkg::CMD_VERTEX);
  assign idx    = s_axis_tdata[vtp_pkg::IDX_LSB +: vtp_pkg::IDX_W];
  assign val    = s_axis_tdata[vtp_pkg::VAL_LSB +: 32];

  // hold loads until every queued vertex has read the store
  assign s_axis_tready = is_vtx ? !flow_i.q_full
                                : !(flow_i.pipe_busy || !flow_i.q_empty);
  assign push_o = s_axis_tvalid && s_axis_tready && is_vtx;
  assign ld_acc = s_axis_tvalid && s_axis_tready && !is_vtx;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      vtx_o.pos[i] = s_axis_tdata[vtp_pkg::POS_LSB + 32*i +: 32];
    end
    for (int i = 0; i < 3; i++) begin
      vtx_o.norm[i] = s_axis_tdata[vtp_pkg::NORM_LSB + 32*i +: 32];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_acc && (idx < vtp_pkg::IDX_W'(vtp_pkg::COEF_COUNT))) begin
      coef_q[idx] <= val;
    end
  end

  assign coef_o = coef_q;

endmodule

`default_nettype wire

// ===== src/vtp_back.sv =====
`default_nettype none

module vtp_back #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire vtp_pkg::coef_arr_t                coef_i,
  input  wire logic                              q_empty_i,
  input  wire vtp_pkg::vtx_t                     q_data_i,
  output logic                                   pop_o,
  output logic                                   busy_o,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [vtp_pkg::OUT_TDATA_W-1:0]        m_axis_tdata
);

  localparam int PW  = 64 - FRAC_BITS;
  localparam int SW  = PW + 2;
  localparam int DW  = 32 + FRAC_BITS;
  localparam int SQN = 32;
  localparam int NST = 4 + SQN + DW;

  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [SW-1:0] sum_t;

  typedef struct packed {
    logic [63:0]                s;
    logic [63:0]                res;
    vtp_pkg::word_t [2:0]       vn;
    vtp_pkg::word_t [3:0]       clip;
  } sqs_t;

  typedef struct packed {
    logic [31:0]    rem;
    logic [DW-1:0]  num;
    logic [DW-1:0]  qt;
    logic           neg;
  } lane_t;

  typedef struct packed {
    lane_t [2:0]            ln;
    logic [31:0]            r;
    vtp_pkg::word_t [3:0]   clip;
  } dvs_t;

  function automatic vtp_pkg::word_t sat_w(input sum_t v);
    vtp_pkg::word_t r;
    if ((v[SW-1:31] == '0) || (v[SW-1:31] == '1)) begin
      r = v[31:0];
    end else if (v[SW-1]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

  function automatic prod_t fx_mul(input vtp_pkg::word_t a, input vtp_pkg::word_t b);
    logic signed [63:0] p;
    p = a * b;
    return p[63:FRAC_BITS];
  endfunction

  logic               en;
  logic [NST-1:0]     vld_q;
  logic               out_vld_q;
  vtp_pkg::result_t   out_q;
  vtp_pkg::result_t   res_d;

  assign en     = !out_vld_q || m_axis_tready;
  assign pop_o  = en && !q_empty_i;
  assign busy_o = |vld_q;

  // stage 1: modelview and normal products
  prod_t mv_p_q [4][4];
  prod_t nm_p_q [3][3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          mv_p_q[r][c] <= fx_mul(coef_i[vtp_pkg::MV_BASE + c*4 + r], q_data_i.pos[c]);
        end
      end
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          nm_p_q[r][c] <= fx_mul(coef_i[vtp_pkg::NM_BASE + c*4 + r], q_data_i.norm[c]);
        end
      end
    end
  end

  // stage 2: row sums
  vtp_pkg::word_t view_d [4];
  vtp_pkg::word_t vn_d   [3];
  vtp_pkg::word_t view_q [4];
  vtp_pkg::word_t vn2_q  [3];

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      view_d[r] = sat_w(SW'(mv_p_q[r][0]) + SW'(mv_p_q[r][1])
                      + SW'(mv_p_q[r][2]) + SW'(mv_p_q[r][3]));
    end
    for (int r = 0; r < 3; r++) begin
      vn_d[r] = sat_w(SW'(nm_p_q[r][0]) + SW'(nm_p_q[r][1]) + SW'(nm_p_q[r][2]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      view_q <= view_d;
      vn2_q  <= vn_d;
    end
  end

  // stage 3: projection products and squares
  prod_t          pj_p_q [4][4];
  logic [63:0]    sqr_q  [3];
  vtp_pkg::word_t vn3_q  [3];
  logic signed [63:0] sqr_d [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sqr_d[i] = vn2_q[i] * vn2_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          pj_p_q[r][c] <= fx_mul(coef_i[vtp_pkg::PJ_BASE + c*4 + r], view_q[c]);
        end
      end
      for (int i = 0; i < 3; i++) begin
        sqr_q[i] <= sqr_d[i];
      end
      vn3_q <= vn2_q;
    end
  end

  // stage 4: clip sums and squared length
  sqs_t sq_q [SQN+1];
  sqs_t sq0_d;

  always_comb begin
    sq0_d.s   = sqr_q[0] + sqr_q[1] + sqr_q[2];
    sq0_d.res = '0;
    for (int i = 0; i < 3; i++) begin
      sq0_d.vn[i] = vn3_q[i];
    end
    for (int r = 0; r < 4; r++) begin
      sq0_d.clip[r] = sat_w(SW'(pj_p_q[r][0]) + SW'(pj_p_q[r][1])
                          + SW'(pj_p_q[r][2]) + SW'(pj_p_q[r][3]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q[0] <= sq0_d;
    end
  end

  // square root, one result bit per stage
  for (genvar k = 0; k < SQN; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2*k);
    logic [63:0] trial;
    sqs_t        nxt;

    always_comb begin
      trial = sq_q[k].res + BIT;
      nxt   = sq_q[k];
      if (sq_q[k].s >= trial) begin
        nxt.s   = sq_q[k].s - trial;
        nxt.res = (sq_q[k].res >> 1) + BIT;
      end else begin
        nxt.res = sq_q[k].res >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_q[k+1] <= nxt;
      end
    end
  end

  // divide, one quotient bit per stage on three lanes
  dvs_t dv_in;
  dvs_t dv_q [1:DW];

  always_comb begin
    dv_in.r    = sq_q[SQN].res[31:0];
    dv_in.clip = sq_q[SQN].clip;
    for (int l = 0; l < 3; l++) begin
      dv_in.ln[l].neg = sq_q[SQN].vn[l][31];
      dv_in.ln[l].num = {(sq_q[SQN].vn[l][31] ? 32'(-sq_q[SQN].vn[l])
                                               : 32'(sq_q[SQN].vn[l])),
                         {FRAC_BITS{1'b0}}};
      dv_in.ln[l].rem = '0;
      dv_in.ln[l].qt  = '0;
    end
  end

  for (genvar j = 0; j < DW; j++) begin : g_div
    dvs_t src;
    dvs_t nxt;
    logic [32:0] t   [3];
    logic        ge  [3];

    if (j == 0) begin : g_first
      assign src = dv_in;
    end else begin : g_rest
      assign src = dv_q[j];
    end

    always_comb begin
      nxt = src;
      for (int l = 0; l < 3; l++) begin
        t[l]  = {src.ln[l].rem, src.ln[l].num[DW-1]};
        ge[l] = (t[l] >= {1'b0, src.r});
        nxt.ln[l].rem = ge[l] ? 32'(t[l] - {1'b0, src.r}) : t[l][31:0];
        nxt.ln[l].num = {src.ln[l].num[DW-2:0], 1'b0};
        nxt.ln[l].qt  = {src.ln[l].qt[DW-2:0], ge[l]};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_q[j+1] <= nxt;
      end
    end
  end

  always_comb begin
    res_d.clip = dv_q[DW].clip;
    for (int l = 0; l < 3; l++) begin
      if (dv_q[DW].r == '0) begin
        res_d.view_norm[l] = '0;
      end else if (dv_q[DW].ln[l].neg) begin
        res_d.view_norm[l] = -$signed(dv_q[DW].ln[l].qt[31:0]);
      end else begin
        res_d.view_norm[l] = dv_q[DW].ln[l].qt[31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[NST-2:0], pop_o};
      out_vld_q <= vld_q[NST-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule

`default_nettype wire

// ===== src/vertex_transform_project_top.sv =====
// Vertex transform and projection with a 48-entry coefficient store.
// Input stream: s_axis_tuser selects the command (0 load coefficient,
// 1 transform vertex); s_axis_tdata carries the item fields. A load writes
// one coefficient of the modelview, normal or projection matrix and gives
// no output beat. A vertex gives one output beat with the clip position and
// the unit view-space normal.
// Throughput: one vertex per cycle unless the queue is full or the output
// stalls. A load waits until all vertices already accepted have left the
// arithmetic pipeline (they read the store while in flight), then is accepted.
// Path from input beat to output beat: the queue, four arithmetic stages,
// the 32-stage square root, the (32 + FRAC_BITS)-stage divider and the
// output register.
// Reset: the queue, the pipeline and the output register empty; the store
// holds nothing valid until written.
// Stall: when m_axis_tready is low while an output beat is valid, the beat
// holds and the whole pipeline freezes; the input queue (QUEUE_DEPTH
// vertices) keeps taking beats until full.
`default_nettype none

module vertex_transform_project_top #(
  parameter int FRAC_BITS   = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // coef_index, coef_value, pos_x, pos_y, pos_z, pos_w, norm_x, norm_y, norm_z
  input  wire logic [vtp_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // cmd
  input  wire logic                              s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // clip_x, clip_y, clip_z, clip_w, view_norm_x, view_norm_y, view_norm_z
  output logic [vtp_pkg::OUT_TDATA_W-1:0]        m_axis_tdata
);

  vtp_pkg::flow_t      flow;
  vtp_pkg::vtx_t       vtx_in;
  vtp_pkg::vtx_t       vtx_q;
  vtp_pkg::coef_arr_t  coef;
  logic                push, pop, full, empty, busy;

  assign flow = '{q_full: full, q_empty: empty, pipe_busy: busy};

  vtp_front u_front (
    .clk_i         (clk_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .flow_i        (flow),
    .push_o        (push),
    .vtx_o         (vtx_in),
    .coef_o        (coef)
  );

  vtp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .din_i   (vtx_in),
    .pop_i   (pop),
    .dout_o  (vtx_q),
    .full_o  (full),
    .empty_o (empty)
  );

  vtp_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .coef_i        (coef),
    .q_empty_i     (empty),
    .q_data_i      (vtx_q),
    .pop_o         (pop),
    .busy_o        (busy),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ===== src/vtp_checker.sv =====
`default_nettype none

module vtp_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              s_axis_tvalid,
  input wire logic                              s_axis_tready,
  input wire logic [vtp_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input wire logic                              s_axis_tuser,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [vtp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  logic ld_beat;
  assign ld_beat = s_axis_tvalid && s_axis_tready
                   && (vtp_pkg::cmd_e'(s_axis_tuser) == vtp_pkg::CMD_LOAD);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid)
    else $error("output valid during reset");

  a_load_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld_beat |=> !$rose(m_axis_tvalid))
    else $error("load accepted with vertices still in flight");

endmodule

bind vertex_transform_project_top vtp_checker u_vtp_checker (.*);

`default_nettype wire

// ===== dv/vertex_transform_project_top_test.sv =====
`default_nettype none

module vertex_transform_project_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam vtp_pkg::word_t ONE = 32'sh0001_0000;
  localparam vtp_pkg::word_t WMAX = 32'sh7fff_ffff;
  localparam vtp_pkg::word_t WMIN = 32'sh8000_0000;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 150;
  localparam int HOLD_CYCLES = 400;

  typedef vtp_pkg::word_t vec4_t[4];

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [vtp_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [vtp_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  vertex_transform_project_top u_top (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  vtp_pkg::word_t coef_mirror[vtp_pkg::COEF_COUNT];
  vtp_pkg::result_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  int vertices_sent = 0;
  int loads_sent = 0;
  int results_seen = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  bit quiet = 1'b0;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic vtp_pkg::word_t row_dot(int base, int r, vec4_t v, int n);
    longint acc;
    acc = 0;
    for (int c = 0; c < n; c++) begin
      acc += (longint'(coef_mirror[base + c * 4 + r]) * longint'(v[c])) >>> FRAC;
    end
    if (acc > longint'(WMAX)) return WMAX;
    if (acc < longint'(WMIN)) return WMIN;
    return vtp_pkg::word_t'(acc);
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] s);
    logic [63:0] res, b;
    res = 0;
    b = 64'h1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s = s - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic vtp_pkg::word_t unit_scale(vtp_pkg::word_t x, logic [63:0] r);
    logic [63:0] mag, q;
    mag = (x < 0) ? 64'(-longint'(x)) : 64'(longint'(x));
    q = (mag << FRAC) / r;
    return (x < 0) ? vtp_pkg::word_t'(-longint'(q)) : vtp_pkg::word_t'(q);
  endfunction

  function automatic vtp_pkg::result_t transform_vertex(vec4_t pos, vec4_t nrm);
    vtp_pkg::result_t res;
    vec4_t view, vn;
    logic [63:0] sq, r;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      vn[i] = row_dot(vtp_pkg::NM_BASE, i, nrm, 3);
      sq += 64'(longint'(vn[i]) * longint'(vn[i]));
    end
    if (sq != 0) begin
      r = floor_sqrt(sq);
      for (int i = 0; i < 3; i++) vn[i] = unit_scale(vn[i], r);
    end
    for (int i = 0; i < 4; i++) view[i] = row_dot(vtp_pkg::MV_BASE, i, pos, 4);
    for (int i = 0; i < 4; i++) res.clip[i] = row_dot(vtp_pkg::PJ_BASE, i, view, 4);
    for (int i = 0; i < 3; i++) res.view_norm[i] = vn[i];
    return res;
  endfunction

  task automatic send_beat(vtp_pkg::cmd_e cmd, logic [5:0] idx, vtp_pkg::word_t val,
                           vec4_t pos, vec4_t nrm);
    logic [vtp_pkg::IN_TDATA_W-1:0] d;
    int gap;
    d = '0;
    d[vtp_pkg::IDX_LSB +: 6] = idx;
    d[vtp_pkg::VAL_LSB +: 32] = val;
    for (int i = 0; i < 4; i++) d[vtp_pkg::POS_LSB + 32 * i +: 32] = pos[i];
    for (int i = 0; i < 3; i++) d[vtp_pkg::NORM_LSB + 32 * i +: 32] = nrm[i];
    gap = (!quiet && $urandom_range(99) < 11) ? 1 : 0;
    for (int g = 0; g < gap; g++) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    if (cmd == vtp_pkg::CMD_LOAD) begin
      loads_sent++;
      if (idx < vtp_pkg::COEF_COUNT) coef_mirror[idx] = val;
    end else begin
      vertices_sent++;
      pending_results.push_back(transform_vertex(pos, nrm));
    end
  endtask

  task automatic load_coef(int idx, vtp_pkg::word_t val);
    vec4_t z = '{default: 0};
    send_beat(vtp_pkg::CMD_LOAD, 6'(idx), val, z, z);
  endtask

  task automatic send_vertex(vec4_t pos, vec4_t nrm);
    send_beat(vtp_pkg::CMD_VERTEX, 6'($urandom), vtp_pkg::word_t'($urandom), pos, nrm);
  endtask

  function automatic vtp_pkg::word_t rand_word();
    case ($urandom_range(9))
      0: return WMAX;
      1: return WMIN;
      2: return 0;
      3: return ($urandom_range(1)) ? ONE : -ONE;
      4, 5: return vtp_pkg::word_t'($urandom);
      default: return vtp_pkg::word_t'($urandom_range(ONE * 8)) - ONE * 4;
    endcase
  endfunction

  always @(posedge clk_i) begin
    vtp_pkg::result_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      got = vtp_pkg::result_t'(m_axis_tdata);
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat %h", $time, m_axis_tdata);
      end else begin
        want = pending_results.pop_front();
        for (int i = 0; i < 4; i++) begin
          if (got.clip[i] !== want.clip[i]) begin
            errors++;
            $display("%0t: clip[%0d] expected %h actual %h", $time, i, want.clip[i],
                     got.clip[i]);
          end
        end
        for (int i = 0; i < 3; i++) begin
          if (got.view_norm[i] !== want.view_norm[i]) begin
            errors++;
            $display("%0t: view_norm[%0d] expected %h actual %h", $time, i,
                     want.view_norm[i], got.view_norm[i]);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= quiet || ($urandom_range(99) >= 11);
    end
  end

  task automatic test_load_identity();
    for (int m = 0; m < 3; m++) begin
      for (int k = 0; k < 16; k++) load_coef(m * 16 + k, (k % 5 == 0) ? ONE : 0);
    end
  endtask

  task automatic test_vertex_extremes();
    send_vertex('{ONE, 2 * ONE, -3 * ONE, ONE}, '{ONE, 0, 0, 0});
    send_vertex('{WMAX, WMIN, 0, -1}, '{WMAX, WMAX, WMAX, 0});
    send_vertex('{WMIN, WMIN, WMIN, WMIN}, '{WMIN, WMIN, WMIN, 0});
    send_vertex('{1, -1, WMAX, ONE}, '{0, -1, 1, 0});
  endtask

  task automatic test_zero_normal();
    send_vertex('{ONE, ONE, ONE, ONE}, '{0, 0, 0, 0});
    for (int k = 0; k < 3; k++) load_coef(vtp_pkg::NM_BASE + k * 5, 0);
    send_vertex('{ONE, ONE, ONE, ONE}, '{ONE, WMAX, WMIN, 0});
    for (int k = 0; k < 3; k++) load_coef(vtp_pkg::NM_BASE + k * 5, ONE);
  endtask

  task automatic test_saturation();
    load_coef(vtp_pkg::MV_BASE + 0, WMAX);
    load_coef(vtp_pkg::MV_BASE + 4, WMAX);
    load_coef(vtp_pkg::PJ_BASE + 1, WMIN);
    send_vertex('{WMAX, WMAX, ONE, ONE}, '{-ONE, ONE, WMIN, 0});
    send_vertex('{WMIN, WMAX, -ONE, WMIN}, '{ONE, ONE, ONE, 0});
  endtask

  task automatic test_ignored_index();
    load_coef(48, WMAX);
    load_coef(63, WMIN);
    send_vertex('{ONE, ONE, ONE, ONE}, '{ONE, ONE, ONE, 0});
  endtask

  task automatic test_random_stream(int count);
    vec4_t pos, nrm;
    for (int n = 0; n < count; n++) begin
      quiet = (n >= count / 3) && (n < count / 2);
      if ($urandom_range(99) < 8) begin
        load_coef($urandom_range(63), rand_word());
      end else begin
        for (int i = 0; i < 4; i++) pos[i] = rand_word();
        for (int i = 0; i < 3; i++) nrm[i] = ($urandom_range(19) == 0) ? 0 : rand_word();
        send_vertex(pos, nrm);
      end
    end
    quiet = 1'b0;
  endtask

  task automatic test_backpressure();
    vec4_t pos, nrm;
    hold_req++;
    for (int n = 0; n < 120; n++) begin
      for (int i = 0; i < 4; i++) pos[i] = rand_word();
      for (int i = 0; i < 3; i++) nrm[i] = rand_word();
      send_vertex(pos, nrm);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_load_identity();
    test_vertex_extremes();
    test_zero_normal();
    test_saturation();
    test_ignored_index();
    test_random_stream(960);
    test_backpressure();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("sent %0d vertices and %0d coefficient loads, checked %0d results",
             vertices_sent, loads_sent, results_seen);
    $display("covered extremes, saturation, zero normals, ignored slots and a long stall");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
